@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files that check themselves (here quad_perimeter_area)
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define QPA_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// checked on every edge, reset included
`define QPA_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/qpa_pkg.sv @@
// types, widths and the square root step for quad_perimeter_area
// no dependencies
package qpa_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int MAG_W       = COORD_WIDTH;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int RAD_W       = 2 * MAG_W + 2;
    localparam int ROOT_W      = MAG_W + 1;
    localparam int REM_W       = ROOT_W + 3;
    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int SHOE_W      = PROD_W + 3;
    localparam int PERIM_W     = 19;
    localparam int AREA_W      = 34;
    localparam int SQRT_STG    = (ROOT_W + 1) / 2;
    localparam int NUM_EDGES   = 4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] d_x;
        logic signed [COORD_WIDTH-1:0] d_y;
    } qpa_in_t;

    typedef struct packed {
        logic [PERIM_W-1:0] perimeter_len;
        logic [AREA_W-1:0]  area_twice;
    } qpa_out_t;

    typedef struct packed {
        logic [NUM_EDGES-1:0][RAD_W-1:0] rad;
        logic signed [SHOE_W-1:0]        shoe;
    } qpa_rad_t;

    typedef struct packed {
        logic [NUM_EDGES-1:0][ROOT_W-1:0] root;
        logic signed [SHOE_W-1:0]         shoe;
    } qpa_root_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } qpa_sq_t;

    typedef struct packed {
        logic [NUM_EDGES-1:0][RAD_W-1:0] rad;
        qpa_sq_t [NUM_EDGES-1:0]         lane;
        logic signed [SHOE_W-1:0]        shoe;
    } qpa_sqp_t;

    // one digit of the restoring square root
    function automatic qpa_sq_t sqrt_step(qpa_sq_t cur, logic [1:0] pair);
        qpa_sq_t          nxt;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        sh    = {cur.rem[REM_W-3:0], pair};
        trial = {1'b0, cur.root, 2'b01};
        if (sh >= trial) begin
            nxt.rem  = sh - trial;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = sh;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

@@ hw/rtl/qpa_geom.sv @@
// edge deltas, squares and shoelace sum, three register stages
// depends on qpa_pkg
module qpa_geom (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  qpa_pkg::qpa_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output qpa_pkg::qpa_rad_t out_data
);
    import qpa_pkg::*;

    logic signed [COORD_WIDTH-1:0] px [NUM_EDGES];
    logic signed [COORD_WIDTH-1:0] py [NUM_EDGES];

    logic                    v1_reg, v2_reg, v3_reg;
    logic                    rdy1, rdy2, rdy3;
    logic [MAG_W-1:0]        mx_reg [NUM_EDGES];
    logic [MAG_W-1:0]        my_reg [NUM_EDGES];
    logic signed [PROD_W-1:0] p_reg [NUM_EDGES];
    logic signed [PROD_W-1:0] q_reg [NUM_EDGES];
    logic [SQ_W-1:0]         sqx_reg [NUM_EDGES];
    logic [SQ_W-1:0]         sqy_reg [NUM_EDGES];
    logic signed [CROSS_W-1:0] cr_reg [NUM_EDGES];
    qpa_rad_t                out_reg;

    logic [MAG_W-1:0]        mx_next [NUM_EDGES];
    logic [MAG_W-1:0]        my_next [NUM_EDGES];
    logic signed [PROD_W-1:0] p_next [NUM_EDGES];
    logic signed [PROD_W-1:0] q_next [NUM_EDGES];
    qpa_rad_t                out_next;

    assign px[0] = in_data.a_x;
    assign py[0] = in_data.a_y;
    assign px[1] = in_data.b_x;
    assign py[1] = in_data.b_y;
    assign px[2] = in_data.c_x;
    assign py[2] = in_data.c_y;
    assign px[3] = in_data.d_x;
    assign py[3] = in_data.d_y;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        logic signed [COORD_WIDTH:0] dx;
        logic signed [COORD_WIDTH:0] dy;
        for (int i = 0; i < NUM_EDGES; i++) begin
            dx = (COORD_WIDTH+1)'(px[i]) - (COORD_WIDTH+1)'(px[(i+1)%NUM_EDGES]);
            dy = (COORD_WIDTH+1)'(py[i]) - (COORD_WIDTH+1)'(py[(i+1)%NUM_EDGES]);
            mx_next[i] = dx[COORD_WIDTH] ? MAG_W'(-dx) : MAG_W'(dx);
            my_next[i] = dy[COORD_WIDTH] ? MAG_W'(-dy) : MAG_W'(dy);
            p_next[i]  = PROD_W'(px[i]) * PROD_W'(py[(i+1)%NUM_EDGES]);
            q_next[i]  = PROD_W'(py[i]) * PROD_W'(px[(i+1)%NUM_EDGES]);
        end
    end

    always_comb begin
        logic signed [SHOE_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < NUM_EDGES; i++) begin
            out_next.rad[i] = RAD_W'(sqx_reg[i]) + RAD_W'(sqy_reg[i]);
            acc = acc + SHOE_W'(cr_reg[i]);
        end
        out_next.shoe = acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            mx_reg <= mx_next;
            my_reg <= my_next;
            p_reg  <= p_next;
            q_reg  <= q_next;
        end
        if (rdy2 && v1_reg) begin
            for (int i = 0; i < NUM_EDGES; i++) begin
                sqx_reg[i] <= SQ_W'(mx_reg[i]) * SQ_W'(mx_reg[i]);
                sqy_reg[i] <= SQ_W'(my_reg[i]) * SQ_W'(my_reg[i]);
                cr_reg[i]  <= CROSS_W'(p_reg[i]) - CROSS_W'(q_reg[i]);
            end
        end
        if (rdy3 && v2_reg) begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

@@ hw/rtl/qpa_isqrt.sv @@
// four-lane pipelined floor square root, two digits per stage (one in the last)
// depends on qpa_pkg; carries the shoelace sum alongside
module qpa_isqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  qpa_pkg::qpa_rad_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qpa_pkg::qpa_root_t out_data
);
    import qpa_pkg::*;

    logic        v_reg [SQRT_STG];
    logic        rdy   [SQRT_STG+1];
    qpa_sqp_t    st_reg  [SQRT_STG];
    qpa_sqp_t    st_next [SQRT_STG];
    qpa_sqp_t    src     [SQRT_STG];
    logic        src_v   [SQRT_STG];

    assign rdy[SQRT_STG] = out_ready;
    assign in_ready      = rdy[0];

    always_comb begin
        src[0].rad  = in_data.rad;
        src[0].lane = '0;
        src[0].shoe = in_data.shoe;
        src_v[0]    = in_valid;
    end

    genvar s;
    generate
        for (s = 0; s < SQRT_STG; s++) begin : g_stg
            if (s > 0) begin : g_link
                assign src[s]   = st_reg[s-1];
                assign src_v[s] = v_reg[s-1];
            end

            assign rdy[s] = !v_reg[s] || rdy[s+1];

            always_comb begin
                qpa_sq_t t;
                st_next[s].shoe = src[s].shoe;
                for (int l = 0; l < NUM_EDGES; l++) begin
                    t = sqrt_step(src[s].lane[l], src[s].rad[l][RAD_W-1 -: 2]);
                    st_next[s].rad[l] = {src[s].rad[l][RAD_W-3:0], 2'b00};
                    if (2 * s + 1 < ROOT_W) begin
                        t = sqrt_step(t, src[s].rad[l][RAD_W-3 -: 2]);
                        st_next[s].rad[l] = {src[s].rad[l][RAD_W-5:0], 4'b0000};
                    end
                    st_next[s].lane[l] = t;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[s] <= 1'b0;
                end else if (rdy[s]) begin
                    v_reg[s] <= src_v[s];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[s] && src_v[s]) begin
                    st_reg[s] <= st_next[s];
                end
            end
        end
    endgenerate

    always_comb begin
        for (int l = 0; l < NUM_EDGES; l++) begin
            out_data.root[l] = st_reg[SQRT_STG-1].lane[l].root;
        end
        out_data.shoe = st_reg[SQRT_STG-1].shoe;
    end

    assign out_valid = v_reg[SQRT_STG-1];

endmodule

@@ hw/rtl/quad_perimeter_area.sv @@
// top level: quadrilateral perimeter and doubled shoelace area
// depends on qpa_pkg, qpa_geom, qpa_isqrt and assert_macros.svh

// Takes one quadrilateral (four signed 8.8 vertices) per transaction and returns
// one result: the sum of the four floored edge lengths and the absolute doubled
// shoelace area. A new transaction is taken every cycle while the result side
// does not stall. From input to output register there are three stages for
// deltas, squares and sums, nine stages for the 17-digit square root at two
// digits per stage (one in the last), and one stage that adds the edge lengths
// and takes the absolute area. Each stage holds its data while the result side
// stalls and fills its bubbles, so the input keeps accepting until every stage is occupied.
`include "assert_macros.svh"

module quad_perimeter_area (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  qpa_pkg::qpa_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output qpa_pkg::qpa_out_t m_payload
);
    import qpa_pkg::*;

    logic      g_valid, g_ready;
    qpa_rad_t  g_data;
    logic      r_valid, r_ready;
    qpa_root_t r_data;

    logic      o_valid_reg;
    qpa_out_t  o_data_reg;
    qpa_out_t  o_data_next;

    qpa_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (g_valid),
        .out_ready (g_ready),
        .out_data  (g_data)
    );

    qpa_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (g_valid),
        .in_ready  (g_ready),
        .in_data   (g_data),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_data  (r_data)
    );

    assign r_ready = !o_valid_reg || m_ready;

    always_comb begin
        logic [PERIM_W-1:0] perim;
        logic [SHOE_W-1:0]  mag;
        perim = '0;
        for (int l = 0; l < NUM_EDGES; l++) begin
            perim = perim + PERIM_W'(r_data.root[l]);
        end
        mag = r_data.shoe[SHOE_W-1] ? SHOE_W'(-r_data.shoe) : SHOE_W'(r_data.shoe);
        o_data_next.perimeter_len = perim;
        o_data_next.area_twice    = mag[AREA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (r_ready) begin
            o_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready && r_valid) begin
            o_data_reg <= o_data_next;
        end
    end

    assign m_valid   = o_valid_reg;
    assign m_payload = o_data_reg;

    // an empty output register means every stage can move
    `QPA_ASSERT(a_ready_when_drained, !m_valid, s_ready)
    // nothing comes out right after reset
    `QPA_ASSERT(a_quiet_after_reset, $past(!aresetn), !m_valid)
    // doubled area never exceeds twice the full coordinate square
    `QPA_ASSERT(a_area_bound, m_valid, m_payload.area_twice <= 34'h200000000)

endmodule

@@ verif/qpa_checker.sv @@
// checker for quad_perimeter_area: predicts perimeter and doubled area per transaction
// watches both channels and compares results in order; depends on qpa_pkg
`timescale 1ns / 1ps

module qpa_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  qpa_pkg::qpa_in_t  s_payload,
    input  logic              m_valid,
    input  logic              m_ready,
    input  qpa_pkg::qpa_out_t m_payload,
    output int                fail_count,
    output int                pending
);
    import qpa_pkg::*;

    qpa_out_t expected_q[$];

    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bit_v;
        root  = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (n >= root + bit_v) begin
                n    = n - (root + bit_v);
                root = (root >> 1) + bit_v;
            end else begin
                root = root >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return root;
    endfunction

    function automatic qpa_out_t quad_measure(qpa_in_t q);
        logic signed [63:0] px[4];
        logic signed [63:0] py[4];
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0] perim;
        logic [63:0] shoe;
        qpa_out_t r;
        int j;
        px[0] = q.a_x; py[0] = q.a_y;
        px[1] = q.b_x; py[1] = q.b_y;
        px[2] = q.c_x; py[2] = q.c_y;
        px[3] = q.d_x; py[3] = q.d_y;
        perim = 0;
        shoe  = 0;
        for (int i = 0; i < 4; i++) begin
            j  = (i + 1) % 4;
            dx = px[i] - px[j];
            dy = py[i] - py[j];
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            perim = perim + floor_root(dx * dx + dy * dy);
            shoe  = shoe + px[i] * py[j] - py[i] * px[j];
        end
        if (shoe[63]) shoe = -shoe;
        r.perimeter_len = perim[PERIM_W-1:0];
        r.area_twice    = shoe[AREA_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = expected_q.size();

    always @(posedge aclk) begin
        qpa_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) expected_q.push_back(quad_measure(s_payload));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_payload.perimeter_len !== want.perimeter_len)
                        report_mismatch("perimeter_len", m_payload.perimeter_len,
                                        want.perimeter_len);
                    if (m_payload.area_twice !== want.area_twice)
                        report_mismatch("area_twice", m_payload.area_twice,
                                        want.area_twice);
                end
            end
        end
    end
endmodule

@@ verif/tb_quad_perimeter_area.sv @@
// testbench top for quad_perimeter_area: directed and random quadrilaterals with
// bursty input and stalling output; depends on qpa_pkg, qpa_checker and the rtl
`timescale 1ns / 1ps

module tb_quad_perimeter_area;
    import qpa_pkg::*;

    logic     aclk = 0;
    logic     aresetn = 0;
    logic     s_valid = 0;
    logic     s_ready;
    qpa_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready = 0;
    qpa_out_t m_payload;
    int       fail_count;
    int       pending;
    bit       hold_off = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    quad_perimeter_area uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    qpa_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // one transaction, held until accepted
    task automatic send_quad(qpa_in_t q);
        s_payload <= q;
        s_valid   <= 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_vertices(logic [15:0] ax, ay, bx, by, cx, cy, dx, dy);
        qpa_in_t q;
        q = {ax, ay, bx, by, cx, cy, dx, dy};
        send_quad(q);
    endtask

    // receiver: own stall pattern, long hold-off on request
    initial begin
        int mode;
        @(negedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (60) @(negedge aclk);
                hold_off = 0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 20)) begin
                if (mode == 0) m_ready <= 1;
                else if (mode == 1) m_ready <= $urandom_range(0, 1);
                else if (mode == 2) m_ready <= ($urandom_range(0, 4) != 0);
                else m_ready <= ($urandom_range(0, 3) == 0);
                @(negedge aclk);
            end
        end
    end

    initial begin
        qpa_in_t q;
        int      gap;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // directed: extremes, degenerate and self-crossing shapes
        send_vertices(0, 0, 0, 0, 0, 0, 0, 0);
        send_vertices(16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                      16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        send_vertices(16'h8000, 16'h8000, 16'h8000, 16'h7fff,
                      16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        send_vertices(16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                      16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_vertices(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                      16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_vertices(0, 0, 256, 0, 256, 256, 0, 256);
        send_vertices(0, 0, 256, 256, 512, 512, 768, 768);
        send_vertices(0, 0, 256, 256, 256, 0, 0, 256);
        send_vertices(100, 100, 100, 100, 300, 400, 300, 400);
        send_vertices(16'h7fff, 0, 0, 16'h7fff, 16'h8000, 0, 0, 16'h8000);
        send_vertices(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                      16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        send_vertices(3, 4, 0, 0, 16'hfffd, 16'hfffc, 1, 1);
        // fill the pipeline behind a long receiver hold-off
        hold_off = 1;
        for (int n = 0; n < 40; n++) begin
            for (int k = 0; k < 8; k++) q[k*16 +: 16] = rand_coord();
            send_quad(q);
        end
        s_valid <= 0;
        // drain fully before the random part
        while (pending != 0) @(negedge aclk);
        for (int n = 0; n < 1050; ) begin
            repeat ($urandom_range(1, 16)) begin
                for (int k = 0; k < 8; k++) q[k*16 +: 16] = rand_coord();
                send_quad(q);
                n++;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
